// ----- rtl/core/btmc_pkg.sv -----
// Package of the Beaver-triple matrix combine block: action codes, register
// indexes, widths and shared types. No dependencies.
package btmc_pkg;

  localparam int unsigned MaxDimDefault = 16;
  localparam int unsigned WordW = 64;
  localparam int unsigned IdxW = 4;
  localparam int unsigned DimW = 5;
  localparam int unsigned PartyW = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [2:0] {
    ActLoadA = 3'd0,
    ActLoadB = 3'd1,
    ActLoadC = 3'd2,
    ActMaskX = 3'd3,
    ActMaskY = 3'd4,
    ActLoadE = 3'd5,
    ActLoadF = 3'd6,
    ActReadZ = 3'd7
  } action_e;

  localparam logic [CfgAddrW-1:0] RegRowsM  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegInnerK = 2'd1;
  localparam logic [CfgAddrW-1:0] RegColsN  = 2'd2;
  localparam logic [CfgAddrW-1:0] RegParty  = 2'd3;

  localparam logic [PartyW-1:0] PartyLow  = 2'd0;
  localparam logic [PartyW-1:0] PartyHigh = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] sum_lo;
    logic [WordW-1:0] sum_hi;
    logic [WordW-1:0] sum_pub;
  } lane_acc_t;

endpackage

// ----- rtl/core/btmc_in_if.sv -----
// Input channel interface of the Beaver-triple matrix combine block.
// Depends on btmc_pkg.
interface btmc_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     action;
  logic [btmc_pkg::IdxW-1:0]      row;
  logic [btmc_pkg::IdxW-1:0]      col;
  logic [btmc_pkg::WordW-1:0]     value_lo;
  logic [btmc_pkg::WordW-1:0]     value_hi;
  modport source (output valid, action, row, col, value_lo, value_hi, input ready);
  modport sink (input valid, action, row, col, value_lo, value_hi, output ready);
endinterface

// ----- rtl/core/btmc_out_if.sv -----
// Output channel interface of the Beaver-triple matrix combine block.
// Depends on btmc_pkg.
interface btmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [btmc_pkg::WordW-1:0] out_lo;
  logic [btmc_pkg::WordW-1:0] out_hi;
  logic                       status;
  modport source (output valid, out_lo, out_hi, status, input ready);
  modport sink (input valid, out_lo, out_hi, status, output ready);
endinterface

// ----- rtl/core/btmc_lane.sv -----
// One multiply-accumulate lane: accumulates E*B + A*F for both share words and
// E*F for the public term. Depends on btmc_pkg.
module btmc_lane (
  input  logic                       clk_i,
  input  logic                       clear_i,
  input  logic                       en_i,
  input  logic [btmc_pkg::WordW-1:0] e_i,
  input  logic [btmc_pkg::WordW-1:0] f_i,
  input  logic [btmc_pkg::WordW-1:0] a_lo_i,
  input  logic [btmc_pkg::WordW-1:0] a_hi_i,
  input  logic [btmc_pkg::WordW-1:0] b_lo_i,
  input  logic [btmc_pkg::WordW-1:0] b_hi_i,
  output btmc_pkg::lane_acc_t        acc_o
);
  // Each 64x64 low-half product is split into 32x32 pieces: the low-by-low
  // product and the two cross products, of which only the low 32 bits count.
  // The pieces are registered, then summed into the product, then accumulated.
  localparam int unsigned WW      = btmc_pkg::WordW;
  localparam int unsigned HW      = WW / 2;
  localparam int unsigned NumProd = 5;

  logic [WW-1:0]       op_x [NumProd];
  logic [WW-1:0]       op_y [NumProd];
  logic [WW-1:0]       ll_q [NumProd];
  logic [HW-1:0]       cr_q [NumProd];
  logic [WW-1:0]       prod_q [NumProd];
  logic                vld_q, vld2_q;
  btmc_pkg::lane_acc_t acc_q;

  // Products in order: E*B low, E*B high, A*F low, A*F high, E*F.
  assign op_x[0] = e_i;    assign op_y[0] = b_lo_i;
  assign op_x[1] = e_i;    assign op_y[1] = b_hi_i;
  assign op_x[2] = a_lo_i; assign op_y[2] = f_i;
  assign op_x[3] = a_hi_i; assign op_y[3] = f_i;
  assign op_x[4] = e_i;    assign op_y[4] = f_i;

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NumProd; p++) begin
      ll_q[p]   <= WW'(op_x[p][HW-1:0]) * WW'(op_y[p][HW-1:0]);
      cr_q[p]   <= op_x[p][HW-1:0] * op_y[p][WW-1:HW] + op_x[p][WW-1:HW] * op_y[p][HW-1:0];
      prod_q[p] <= ll_q[p] + {cr_q[p], {HW{1'b0}}};
    end
    vld_q  <= en_i;
    vld2_q <= vld_q;
    if (clear_i) begin
      acc_q <= '0;
    end else if (vld2_q) begin
      acc_q.sum_lo  <= acc_q.sum_lo + prod_q[0] + prod_q[2];
      acc_q.sum_hi  <= acc_q.sum_hi + prod_q[1] + prod_q[3];
      acc_q.sum_pub <= acc_q.sum_pub + prod_q[4];
    end
  end

  assign acc_o = acc_q;
endmodule

// ----- rtl/core/btmc_merge.sv -----
// Merging stage: adds the lane accumulators and C into Z, and the public term
// into z_lo for PartyLow or z_hi for PartyHigh. Depends on btmc_pkg.
module btmc_merge (
  input  logic                        clk_i,
  input  btmc_pkg::lane_acc_t         acc0_i,
  input  btmc_pkg::lane_acc_t         acc1_i,
  input  logic [btmc_pkg::WordW-1:0]  c_lo_i,
  input  logic [btmc_pkg::WordW-1:0]  c_hi_i,
  input  logic [btmc_pkg::PartyW-1:0] party_i,
  output logic [btmc_pkg::WordW-1:0]  z_lo_o,
  output logic [btmc_pkg::WordW-1:0]  z_hi_o
);
  logic [btmc_pkg::WordW-1:0] pub, lo_d, hi_d;

  always_comb begin
    pub  = acc0_i.sum_pub + acc1_i.sum_pub;
    lo_d = c_lo_i + acc0_i.sum_lo + acc1_i.sum_lo;
    hi_d = c_hi_i + acc0_i.sum_hi + acc1_i.sum_hi;
    if (party_i == btmc_pkg::PartyLow) begin
      lo_d = lo_d + pub;
    end else if (party_i == btmc_pkg::PartyHigh) begin
      hi_d = hi_d + pub;
    end
  end

  always_ff @(posedge clk_i) begin
    z_lo_o <= lo_d;
    z_hi_o <= hi_d;
  end
endmodule

// ----- rtl/core/beaver_triple_matmul_combine_top.sv -----
// Top level of the Beaver-triple matrix combine block. Depends on btmc_pkg,
// btmc_in_if, btmc_out_if, btmc_lane and btmc_merge.
//
// The block holds the triple shares A, B and C and the opened matrices E and
// F, one element per transaction, in on-chip memories of MAX_DIM*MAX_DIM words
// each. A load, or any transaction whose index is out of range, presents its
// result in the cycle after acceptance; a mask first passes through StRead and
// StOut. A read of a Z element walks the inner dimension with two
// multiply-accumulate lanes, one taking even and the other odd inner indexes,
// each fed by its own bank of the A, B, E and F memories; it issues the index
// pairs in StIssue, waits in StDrain for the memory read, the two-stage
// multiply and the accumulate, and merges in StMerge. The block handles one
// transaction at a time; the next is accepted in the cycle after the result
// transaction has left.
// No clearing pass is made at reset: memory content is undefined until written.
module beaver_triple_matmul_combine_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [btmc_pkg::CfgAddrW-1:0]  cfg_idx_i,
  input  logic [btmc_pkg::CfgDataW-1:0]  cfg_data_i,
  btmc_in_if.sink                        in_if,
  btmc_out_if.source                     out_if
);
  localparam int unsigned IW    = btmc_pkg::IdxW;
  localparam int unsigned WW    = btmc_pkg::WordW;
  localparam int unsigned Cells = 1 << (2 * IW);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned HalfCells = Cells / 2;
  localparam int unsigned HAW   = AW - 1;
  // The largest dimension matches the four-bit index fields that size storage.
  localparam logic [btmc_pkg::DimW:0] MaxDimW =
      (btmc_pkg::DimW+1)'(btmc_pkg::MaxDimDefault);

  typedef enum logic [2:0] {StIdle, StRead, StIssue, StDrain, StMerge, StOut} state_e;

  // Configuration registers.
  logic [btmc_pkg::DimW-1:0]   rows_q, inner_q, cols_q;
  logic [btmc_pkg::PartyW-1:0] party_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= btmc_pkg::DimW'(1);
      inner_q <= btmc_pkg::DimW'(1);
      cols_q  <= btmc_pkg::DimW'(1);
      party_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btmc_pkg::RegRowsM:  rows_q  <= cfg_data_i;
        btmc_pkg::RegInnerK: inner_q <= cfg_data_i;
        btmc_pkg::RegColsN:  cols_q  <= cfg_data_i;
        btmc_pkg::RegParty:  party_q <= cfg_data_i[btmc_pkg::PartyW-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions clamped into 1..MAX_DIM.
  function automatic logic [btmc_pkg::DimW:0] clamp_dim(input logic [btmc_pkg::DimW-1:0] raw,
                                                       input logic [btmc_pkg::DimW:0] maxd);
    logic [btmc_pkg::DimW:0] r;
    r = {1'b0, raw};
    if (r == '0) r = (btmc_pkg::DimW+1)'(1);
    else if (r > maxd) r = maxd;
    return r;
  endfunction

  logic [btmc_pkg::DimW:0] dim_m, dim_k, dim_n;
  assign dim_m = clamp_dim(rows_q, MaxDimW);
  assign dim_k = clamp_dim(inner_q, MaxDimW);
  assign dim_n = clamp_dim(cols_q, MaxDimW);

  // Memories. A, B, E and F are banked by inner index parity: A and E by the
  // column bit, B and F by the row bit. C is unbanked.
  logic [WW-1:0] a_lo_mem0 [HalfCells], a_lo_mem1 [HalfCells];
  logic [WW-1:0] a_hi_mem0 [HalfCells], a_hi_mem1 [HalfCells];
  logic [WW-1:0] e_mem0 [HalfCells], e_mem1 [HalfCells];
  logic [WW-1:0] b_lo_mem0 [HalfCells], b_lo_mem1 [HalfCells];
  logic [WW-1:0] b_hi_mem0 [HalfCells], b_hi_mem1 [HalfCells];
  logic [WW-1:0] f_mem0 [HalfCells], f_mem1 [HalfCells];
  logic [WW-1:0] c_lo_mem [Cells], c_hi_mem [Cells];

  state_e              state_q;
  logic [2:0]          act_q;
  logic [IW-1:0]       row_q, col_q;
  logic [WW-1:0]       vlo_q, vhi_q;
  logic [IW:0]         t_q;       // next even inner index issued
  logic [2:0]          drain_q;
  logic                out_valid_q, out_status_q;
  logic [WW-1:0]       out_lo_q, out_hi_q;

  logic accept;
  assign in_if.ready = (state_q == StIdle) && !out_valid_q;
  assign accept = in_if.valid && in_if.ready;

  // Range check on the incoming transaction.
  logic [btmc_pkg::DimW:0] rlim, clim;
  logic                    in_range;
  always_comb begin
    case (in_if.action)
      btmc_pkg::ActLoadA, btmc_pkg::ActMaskX, btmc_pkg::ActLoadE: begin
        rlim = dim_m; clim = dim_k;
      end
      btmc_pkg::ActLoadB, btmc_pkg::ActMaskY, btmc_pkg::ActLoadF: begin
        rlim = dim_k; clim = dim_n;
      end
      default: begin
        rlim = dim_m; clim = dim_n;
      end
    endcase
    in_range = ({1'b0, in_if.row} < rlim) && ({1'b0, in_if.col} < clim);
  end

  // Write ports: one write per accepted load whose index is in range.
  logic [AW-1:0]  w_addr;
  logic [HAW-1:0] w_a_addr, w_b_addr;
  assign w_addr   = {in_if.row, in_if.col};
  assign w_a_addr = {in_if.row, in_if.col[IW-1:1]};
  assign w_b_addr = {in_if.row[IW-1:1], in_if.col};

  logic wr;
  assign wr = accept && in_range;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      case (in_if.action)
        btmc_pkg::ActLoadA: begin
          if (in_if.col[0]) begin
            a_lo_mem1[w_a_addr] <= in_if.value_lo; a_hi_mem1[w_a_addr] <= in_if.value_hi;
          end else begin
            a_lo_mem0[w_a_addr] <= in_if.value_lo; a_hi_mem0[w_a_addr] <= in_if.value_hi;
          end
        end
        btmc_pkg::ActLoadE: begin
          if (in_if.col[0]) e_mem1[w_a_addr] <= in_if.value_lo;
          else e_mem0[w_a_addr] <= in_if.value_lo;
        end
        btmc_pkg::ActLoadB: begin
          if (in_if.row[0]) begin
            b_lo_mem1[w_b_addr] <= in_if.value_lo; b_hi_mem1[w_b_addr] <= in_if.value_hi;
          end else begin
            b_lo_mem0[w_b_addr] <= in_if.value_lo; b_hi_mem0[w_b_addr] <= in_if.value_hi;
          end
        end
        btmc_pkg::ActLoadF: begin
          if (in_if.row[0]) f_mem1[w_b_addr] <= in_if.value_lo;
          else f_mem0[w_b_addr] <= in_if.value_lo;
        end
        btmc_pkg::ActLoadC: begin
          c_lo_mem[w_addr] <= in_if.value_lo; c_hi_mem[w_addr] <= in_if.value_hi;
        end
        default: ;
      endcase
    end
  end

  // Read ports. The A/E read address is (row, t/2) and the B/F address
  // (t/2, col), so both lanes share one address per bank group. In StRead the
  // address points at the masked element instead.
  logic [HAW-1:0] ra_addr, rb_addr;
  logic [AW-1:0]  rc_addr;
  logic [IW-2:0]  half_t;
  assign half_t = t_q[IW-1:1];
  always_comb begin
    if (state_q == StRead) begin
      ra_addr = {row_q, col_q[IW-1:1]};
      rb_addr = {row_q[IW-1:1], col_q};
    end else begin
      ra_addr = {row_q, half_t};
      rb_addr = {half_t, col_q};
    end
  end
  assign rc_addr = {row_q, col_q};

  logic [WW-1:0] ra_lo0, ra_lo1, ra_hi0, ra_hi1, re0, re1;
  logic [WW-1:0] rb_lo0, rb_lo1, rb_hi0, rb_hi1, rf0, rf1;
  logic [WW-1:0] rc_lo, rc_hi;
  always_ff @(posedge clk_i) begin
    ra_lo0 <= a_lo_mem0[ra_addr]; ra_lo1 <= a_lo_mem1[ra_addr];
    ra_hi0 <= a_hi_mem0[ra_addr]; ra_hi1 <= a_hi_mem1[ra_addr];
    re0    <= e_mem0[ra_addr];    re1    <= e_mem1[ra_addr];
    rb_lo0 <= b_lo_mem0[rb_addr]; rb_lo1 <= b_lo_mem1[rb_addr];
    rb_hi0 <= b_hi_mem0[rb_addr]; rb_hi1 <= b_hi_mem1[rb_addr];
    rf0    <= f_mem0[rb_addr];    rf1    <= f_mem1[rb_addr];
    rc_lo  <= c_lo_mem[rc_addr];  rc_hi  <= c_hi_mem[rc_addr];
  end

  // Lane enables, delayed to line up with the registered memory data. The odd
  // lane works only while the odd inner index t+1 is below k.
  logic issue, issue_odd, en0_q, en1_q, clear;
  assign issue     = (state_q == StIssue);
  assign issue_odd = ({1'b0, t_q} + (IW+2)'(1)) < dim_k;
  assign clear     = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en0_q <= 1'b0;
      en1_q <= 1'b0;
    end else begin
      en0_q <= issue;
      en1_q <= issue && issue_odd;
    end
  end

  btmc_pkg::lane_acc_t acc0, acc1;

  btmc_lane u_lane0 (
    .clk_i, .clear_i(clear), .en_i(en0_q),
    .e_i(re0), .f_i(rf0), .a_lo_i(ra_lo0), .a_hi_i(ra_hi0),
    .b_lo_i(rb_lo0), .b_hi_i(rb_hi0), .acc_o(acc0)
  );

  btmc_lane u_lane1 (
    .clk_i, .clear_i(clear), .en_i(en1_q),
    .e_i(re1), .f_i(rf1), .a_lo_i(ra_lo1), .a_hi_i(ra_hi1),
    .b_lo_i(rb_lo1), .b_hi_i(rb_hi1), .acc_o(acc1)
  );

  logic [WW-1:0] z_lo, z_hi;
  btmc_merge u_merge (
    .clk_i, .acc0_i(acc0), .acc1_i(acc1), .c_lo_i(rc_lo), .c_hi_i(rc_hi),
    .party_i(party_q), .z_lo_o(z_lo), .z_hi_o(z_hi)
  );

  // Sequencer and result register.
  logic [IW:0] t_next;
  assign t_next = t_q + (IW+1)'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      t_q          <= '0;
      drain_q      <= '0;
      act_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
    end else begin
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            act_q <= in_if.action;
            row_q <= in_if.row;
            col_q <= in_if.col;
            vlo_q <= in_if.value_lo;
            vhi_q <= in_if.value_hi;
            t_q   <= '0;
            if (!in_range) begin
              out_valid_q <= 1'b1; out_status_q <= 1'b1;
              out_lo_q <= '0; out_hi_q <= '0;
            end else if (in_if.action == btmc_pkg::ActReadZ) begin
              state_q <= StIssue;
            end else if (in_if.action == btmc_pkg::ActMaskX ||
                         in_if.action == btmc_pkg::ActMaskY) begin
              state_q <= StRead;
            end else begin
              out_valid_q <= 1'b1; out_status_q <= 1'b0;
              out_lo_q <= '0; out_hi_q <= '0;
            end
          end
        end
        StRead: begin
          state_q <= StOut;
        end
        StOut: begin
          // Memory data registered; pick the bank by the low address bit.
          state_q <= StIdle;
          out_valid_q  <= 1'b1;
          out_status_q <= 1'b0;
          if (act_q == btmc_pkg::ActMaskX) begin
            out_lo_q <= vlo_q - (col_q[0] ? ra_lo1 : ra_lo0);
            out_hi_q <= vhi_q - (col_q[0] ? ra_hi1 : ra_hi0);
          end else begin
            out_lo_q <= vlo_q - (row_q[0] ? rb_lo1 : rb_lo0);
            out_hi_q <= vhi_q - (row_q[0] ? rb_hi1 : rb_hi0);
          end
        end
        StIssue: begin
          t_q <= t_next;
          if ({1'b0, t_next} >= dim_k) begin
            state_q <= StDrain;
            drain_q <= '0;
          end
        end
        StDrain: begin
          // Memory read, the two product stages and the accumulate settle; the
          // merge register takes the final sums on the last drain cycle.
          drain_q <= drain_q + 3'd1;
          if (drain_q == 3'd3) state_q <= StMerge;
        end
        StMerge: begin
          state_q <= StIdle;
          out_valid_q  <= 1'b1;
          out_status_q <= 1'b0;
          out_lo_q <= z_lo;
          out_hi_q <= z_hi;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.out_lo = out_lo_q;
  assign out_if.out_hi = out_hi_q;
  assign out_if.status = out_status_q;
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the Beaver-triple matrix combine block.
// Depends on btmc_pkg, btmc_in_if, btmc_out_if and beaver_triple_matmul_combine_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import btmc_pkg::*;

  localparam int unsigned Dim = 16;
  localparam int unsigned Cells = Dim * Dim;
  localparam int unsigned CycleLimit = 500000;

  typedef struct packed {
    action_e     action;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [63:0] lo;
    logic [63:0] hi;
  } share_txn_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        status;
  } share_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgAddrW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  btmc_in_if  in_ch ();
  btmc_out_if out_ch ();

  beaver_triple_matmul_combine_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // The testbench's own image of the block: share stores, public stores and
  // the registers, together with a record of which cells have been written.
  logic [63:0] a_lo_m [Cells];
  logic [63:0] a_hi_m [Cells];
  logic [63:0] b_lo_m [Cells];
  logic [63:0] b_hi_m [Cells];
  logic [63:0] c_lo_m [Cells];
  logic [63:0] c_hi_m [Cells];
  logic [63:0] e_pub_m [Cells];
  logic [63:0] f_pub_m [Cells];
  bit a_set [Cells];
  bit b_set [Cells];
  bit c_set [Cells];
  bit e_set [Cells];
  bit f_set [Cells];
  logic [4:0] rows_r, inner_r, cols_r;
  logic [1:0] party_r;

  share_res_t z_expected [$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(logic [4:0] raw);
    if (raw == 0) return 1;
    if (raw > Dim) return Dim;
    return raw;
  endfunction

  // Row and column limits of the matrix that an action addresses.
  task automatic shape_of(input action_e act, output int unsigned rl, output int unsigned cl);
    case (act)
      ActLoadA, ActMaskX, ActLoadE: begin
        rl = eff_dim(rows_r);
        cl = eff_dim(inner_r);
      end
      ActLoadB, ActMaskY, ActLoadF: begin
        rl = eff_dim(inner_r);
        cl = eff_dim(cols_r);
      end
      default: begin
        rl = eff_dim(rows_r);
        cl = eff_dim(cols_r);
      end
    endcase
  endtask

  // A mask or a read that would touch a cell never written is turned into
  // the load of the first missing cell, so no undefined content is read.
  task automatic fill_missing(inout share_txn_t t);
    int unsigned rl, cl, k, idx;
    bit found;
    shape_of(t.action, rl, cl);
    if (t.row >= rl || t.col >= cl) return;
    idx = t.row * Dim + t.col;
    k = eff_dim(inner_r);
    found = 0;
    case (t.action)
      ActMaskX: if (!a_set[idx]) t.action = ActLoadA;
      ActMaskY: if (!b_set[idx]) t.action = ActLoadB;
      ActReadZ: begin
        if (!c_set[idx]) begin
          t.action = ActLoadC;
        end else begin
          for (int unsigned s = 0; s < k && !found; s++) begin
            if (!e_set[t.row * Dim + s]) begin
              t.action = ActLoadE; t.col = s[3:0]; found = 1;
            end else if (!a_set[t.row * Dim + s]) begin
              t.action = ActLoadA; t.col = s[3:0]; found = 1;
            end else if (!b_set[s * Dim + t.col]) begin
              t.action = ActLoadB; t.row = s[3:0]; found = 1;
            end else if (!f_set[s * Dim + t.col]) begin
              t.action = ActLoadF; t.row = s[3:0]; found = 1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Updates the image for one accepted transaction and queues its result.
  task automatic predict_share(input share_txn_t t);
    share_res_t r;
    int unsigned rl, cl, k, idx, it, tj;
    logic [63:0] pub;
    r = '0;
    pub = '0;
    shape_of(t.action, rl, cl);
    k = eff_dim(inner_r);
    if (t.row >= rl || t.col >= cl) begin
      r.status = 1'b1;
    end else begin
      idx = t.row * Dim + t.col;
      case (t.action)
        ActLoadA: begin a_lo_m[idx] = t.lo; a_hi_m[idx] = t.hi; a_set[idx] = 1; end
        ActLoadB: begin b_lo_m[idx] = t.lo; b_hi_m[idx] = t.hi; b_set[idx] = 1; end
        ActLoadC: begin c_lo_m[idx] = t.lo; c_hi_m[idx] = t.hi; c_set[idx] = 1; end
        ActLoadE: begin e_pub_m[idx] = t.lo; e_set[idx] = 1; end
        ActLoadF: begin f_pub_m[idx] = t.lo; f_set[idx] = 1; end
        ActMaskX: begin r.lo = t.lo - a_lo_m[idx]; r.hi = t.hi - a_hi_m[idx]; end
        ActMaskY: begin r.lo = t.lo - b_lo_m[idx]; r.hi = t.hi - b_hi_m[idx]; end
        default: begin
          r.lo = c_lo_m[idx];
          r.hi = c_hi_m[idx];
          for (int unsigned s = 0; s < k; s++) begin
            it = t.row * Dim + s;
            tj = s * Dim + t.col;
            r.lo += e_pub_m[it] * b_lo_m[tj] + a_lo_m[it] * f_pub_m[tj];
            r.hi += e_pub_m[it] * b_hi_m[tj] + a_hi_m[it] * f_pub_m[tj];
            pub += e_pub_m[it] * f_pub_m[tj];
          end
          if (party_r == PartyLow) r.lo += pub;
          else if (party_r == PartyHigh) r.hi += pub;
        end
      endcase
    end
    z_expected.push_back(r);
  endtask

  // Sends one transaction. The sender runs in bursts; valid stays high
  // between transactions of a burst and drops only during a gap.
  task automatic send_share(input action_e act, input int unsigned row, input int unsigned col,
                            input logic [63:0] lo, input logic [63:0] hi);
    share_txn_t t;
    t = '{act, row[3:0], col[3:0], lo, hi};
    fill_missing(t);
    in_ch.valid    <= 1'b1;
    in_ch.action   <= t.action;
    in_ch.row      <= t.row;
    in_ch.col      <= t.col;
    in_ch.value_lo <= t.lo;
    in_ch.value_hi <= t.hi;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_share(t);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Waits until every expected result has come back and the block is quiet,
  // then writes all four registers.
  task automatic set_shape(input logic [4:0] m, input logic [4:0] k, input logic [4:0] n,
                           input logic [1:0] party);
    in_ch.valid <= 1'b0;
    while (z_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegRowsM;  cfg_data_i <= m;
    @(posedge clk_i);
    cfg_idx_i <= RegInnerK; cfg_data_i <= k;
    @(posedge clk_i);
    cfg_idx_i <= RegColsN;  cfg_data_i <= n;
    @(posedge clk_i);
    cfg_idx_i <= RegParty;  cfg_data_i <= {3'b000, party};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rows_r = m; inner_r = k; cols_r = n; party_r = party;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Receiver: checks each accepted result against the oldest expectation and
  // stalls on a randomly picked pattern: always ready, ready at random, or seldom ready.
  logic [1:0] stall_mode;
  always @(posedge clk_i) begin
    share_res_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (z_expected.size() == 0) begin
        report_mismatch("unexpected result", out_ch.out_lo, '0);
      end else begin
        w = z_expected.pop_front();
        if (out_ch.out_lo !== w.lo) report_mismatch("out_lo", out_ch.out_lo, w.lo);
        if (out_ch.out_hi !== w.hi) report_mismatch("out_hi", out_ch.out_hi, w.hi);
        if (out_ch.status !== w.status) begin
          report_mismatch("status", {63'b0, out_ch.status}, {63'b0, w.status});
        end
      end
    end
    if (cycles % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0, 2'd3: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Extremes of the words, every action and each index out of range.
  task automatic test_directed();
    set_shape(5'd2, 5'd3, 5'd4, 2'd0);
    send_share(ActLoadA, 0, 0, '1, '0);
    send_share(ActLoadA, 1, 2, 64'h8000_0000_0000_0001, '1);
    send_share(ActLoadA, 2, 0, '1, '1);
    send_share(ActLoadB, 3, 0, '1, '1);
    send_share(ActLoadC, 0, 4, '1, '1);
    send_share(ActLoadE, 0, 3, '1, '1);
    send_share(ActLoadF, 3, 3, '1, '1);
    send_share(ActMaskX, 0, 0, '0, '0);
    send_share(ActMaskX, 1, 2, '1, '0);
    send_share(ActMaskY, 3, 0, '0, '0);
    send_share(ActMaskY, 15, 15, '1, '1);
    send_share(ActMaskX, 15, 0, '1, '1);
    for (int unsigned s = 0; s < 3; s++) begin
      send_share(ActLoadE, 1, s, '1, '0);
      send_share(ActLoadA, 1, s, '1, 64'h1);
      send_share(ActLoadB, s, 3, 64'h1, '1);
      send_share(ActLoadF, s, 3, '1, '0);
    end
    send_share(ActLoadC, 1, 3, '1, '1);
    send_share(ActReadZ, 1, 3, '0, '0);
    send_share(ActReadZ, 2, 0, '0, '0);
    send_share(ActReadZ, 1, 4, '0, '0);
  endtask

  // Random transactions under one register setting: mostly in range, with the
  // reads and masks filling in whatever they need first.
  task automatic test_random_shape(input int unsigned count);
    action_e act;
    int unsigned rl, cl, r, c;
    for (int unsigned i = 0; i < count; i++) begin
      act = action_e'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) act = ActReadZ;
      shape_of(act, rl, cl);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
      end else begin
        r = $urandom_range(0, rl - 1);
        c = $urandom_range(0, cl - 1);
      end
      send_share(act, r, c, rand_word(), rand_word());
    end
  endtask

  // Dimension values of zero and above the maximum are clamped by the block.
  task automatic test_clamped_dims();
    set_shape(5'd0, 5'd31, 5'd17, 2'd3);
    test_random_shape(120);
    set_shape(5'd31, 5'd0, 5'd0, 2'd1);
    test_random_shape(80);
  endtask

  task automatic test_random();
    set_shape(5'd1, 5'd1, 5'd1, 2'd0);
    test_random_shape(60);
    set_shape(5'd16, 5'd16, 5'd16, 2'd2);
    test_random_shape(300);
    set_shape(5'd3, 5'd2, 5'd5, 2'd1);
    test_random_shape(150);
    for (int unsigned p = 0; p < 4; p++) begin
      set_shape(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                5'($urandom_range(1, 16)), p[1:0]);
      test_random_shape(135);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value_lo = '0;
    in_ch.value_hi = '0;
    out_ch.ready = 1'b0;
    stall_mode = '0;
    cycles = 0;
    mismatches = 0;
    burst_left = 0;
    rows_r = 5'd1; inner_r = 5'd1; cols_r = 5'd1; party_r = 2'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_clamped_dims();
    test_random();
    in_ch.valid <= 1'b0;
    while (z_expected.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/btmc_pkg.sv
rtl/core/btmc_in_if.sv
rtl/core/btmc_out_if.sv
rtl/core/btmc_lane.sv
rtl/core/btmc_merge.sv
rtl/core/beaver_triple_matmul_combine_top.sv
tb/sv/testbench.sv
